// ===== design/gtli_pkg.sv =====
// Package: shared types, constants and codes for the grouped time/location index.
`default_nettype none
package gtli_pkg;
	localparam int ENTRY_CAPACITY = 64;
	localparam int GROUP_CAPACITY = 8;
	localparam int EW = $clog2(ENTRY_CAPACITY);
	localparam int CW = $clog2(ENTRY_CAPACITY + 1);
	localparam int GW = 3;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0, OP_NEW = 3'd1, OP_SEL = 3'd2,
		OP_CERT = 3'd3, OP_FLOC = 3'd4, OP_FTS = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_NOTFOUND = 3'd1, ST_FULL = 3'd2,
		ST_NOGROUP = 3'd3, ST_GFULL = 3'd4
	} status_t;

	typedef struct packed {
		logic [2:0]         op;
		logic [63:0]        location;
		logic signed [63:0] timestamp;
		logic [7:0]         group_number;
		logic [1:0]         certainty;
	} in_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [63:0]        found_location;
		logic signed [63:0] found_timestamp;
		logic [2:0]         current_group_out;
		logic [1:0]         current_certainty_out;
	} out_t;

	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_SCAN, S_READ, S_NEXTG, S_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // capture input beat
		logic exec;     // non-scan operations, prefilter setup
		logic scan;     // examine one entry
		logic read;     // hit found; read registers keep the matching entry
		logic nextg;    // move timestamp search to next group
		logic fin_miss; // finish with not-found
		logic fin_hit;  // finish with hit
		logic fin_ok;   // finish with exec status
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_find;   // op needs a scan
		logic pass;      // current group passes prefilter
		logic hit;       // current entry matches
		logic scan_end;  // entry pointer at bottom
		logic more_grp;  // another group remains to try
	} sts_t;
endpackage
`default_nettype wire

// ===== design/gtli_ctrl.sv =====
// Controller: sequences operations and the entry scan.
`default_nettype none
module gtli_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire gtli_pkg::sts_t sts,
	output gtli_pkg::cmd_t     cmd
);
	import gtli_pkg::*;
	state_t state_q, nxt;
	logic ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q <= 1'b0;
		end else begin
			state_q <= nxt;
			if (cmd.fin_miss || cmd.fin_hit || cmd.fin_ok) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	assign out_valid = ov_q;

	always_comb begin
		nxt = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				nxt = sts.is_find ? S_SCAN : S_DONE;
			end
			S_SCAN: begin
				if (!sts.pass) nxt = S_NEXTG;
				else begin
					cmd.scan = 1'b1;
					if (sts.hit) nxt = S_READ;
					else if (sts.scan_end) nxt = S_NEXTG;
				end
			end
			S_READ: begin
				cmd.read = 1'b1;
				nxt = S_DONE;
			end
			S_NEXTG: begin
				if (sts.more_grp) begin
					cmd.nextg = 1'b1;
					nxt = S_SCAN;
				end else begin
					cmd.fin_miss = 1'b1;
					nxt = S_IDLE;
				end
			end
			S_DONE: begin
				if (!ov_q || out_ready) begin
					if (sts.is_find) cmd.fin_hit = 1'b1;
					else cmd.fin_ok = 1'b1;
					nxt = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
		if (state_q == S_NEXTG && !sts.more_grp && ov_q && !out_ready) begin
			cmd.fin_miss = 1'b0;
			nxt = S_NEXTG;
		end
	end
endmodule
`default_nettype wire

// ===== design/gtli_dp.sv =====
// Datapath: entry memory, group bounds, scan pointer and result register.
`default_nettype none
module gtli_dp (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire gtli_pkg::in_t  in_data,
	input  wire gtli_pkg::cmd_t cmd,
	output gtli_pkg::sts_t      sts,
	output gtli_pkg::out_t      out_data
);
	import gtli_pkg::*;

	logic [63:0] mem_loc [ENTRY_CAPACITY];
	logic [63:0] mem_ts  [ENTRY_CAPACITY];
	logic [GW-1:0] mem_tag [ENTRY_CAPACITY];

	logic [63:0] minl_q [GROUP_CAPACITY];
	logic [63:0] maxl_q [GROUP_CAPACITY];
	logic [63:0] mint_q [GROUP_CAPACITY];
	logic [63:0] maxt_q [GROUP_CAPACITY];
	logic [1:0]  cert_q [GROUP_CAPACITY];
	logic [GROUP_CAPACITY-1:0] ne_q;

	logic [CW-1:0] cnt_q;
	logic [GW-1:0] cur_q, high_q;
	in_t req_q;
	logic [2:0] st_q;
	logic [EW-1:0] ptr_q;     // entry under test
	logic [GW-1:0] grp_q;     // group under test
	logic [GW:0]   k_q;       // next group in ascending pass
	logic [63:0] rd_loc_q, rd_ts_q;
	logic [GW-1:0] rd_tag_q;
	logic rd_ok_q;            // read registers hold entry ptr_q
	out_t res_q;

	logic [63:0] key, lo, hi, rd_key;
	logic cmp_signed, pass, hit;
	logic [63:0] tsx, ktx;

	assign tsx = req_q.timestamp ^ 64'h8000000000000000;
	assign cmp_signed = (req_q.op == OP_FTS);
	assign key = cmp_signed ? tsx : req_q.location;
	assign lo  = cmp_signed ? (mint_q[grp_q] ^ 64'h8000000000000000) : minl_q[grp_q];
	assign hi  = cmp_signed ? (maxt_q[grp_q] ^ 64'h8000000000000000) : maxl_q[grp_q];
	assign pass = ne_q[grp_q] && key >= lo && key <= hi && cnt_q != '0;
	assign rd_key = cmp_signed ? rd_ts_q : rd_loc_q;
	assign ktx = cmp_signed ? req_q.timestamp : req_q.location;
	assign hit = rd_ok_q && rd_tag_q == grp_q && rd_key == ktx;

	always_comb begin
		sts.is_find = (req_q.op == OP_FLOC) || (req_q.op == OP_FTS);
		sts.pass = pass && rd_ok_q;
		if (!pass) sts.pass = 1'b0;
		sts.hit = hit;
		sts.scan_end = (ptr_q == '0);
		sts.more_grp = cmp_signed && (k_q <= {1'b0, high_q});
	end

	// memory read, one entry per cycle; on a hit the pointer holds, so the
	// read registers keep the matching entry
	logic [EW-1:0] rd_addr;
	always_comb begin
		rd_addr = ptr_q;
		if (cmd.scan && !hit) rd_addr = ptr_q - 1'b1;
		if (cmd.exec || cmd.nextg) rd_addr = EW'(cnt_q - 1'b1);
	end

	always_ff @(posedge clk) begin
		rd_loc_q <= mem_loc[rd_addr];
		rd_ts_q  <= mem_ts[rd_addr];
		rd_tag_q <= mem_tag[rd_addr];
		if (cmd.exec && req_q.op == OP_ADD && cnt_q < CW'(ENTRY_CAPACITY)) begin
			mem_loc[cnt_q[EW-1:0]] <= req_q.location;
			mem_ts[cnt_q[EW-1:0]]  <= req_q.timestamp;
			mem_tag[cnt_q[EW-1:0]] <= cur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; cur_q <= '0; high_q <= '0; ne_q <= '0;
			for (int i = 0; i < GROUP_CAPACITY; i++) cert_q[i] <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			rd_ok_q <= cmd.exec || cmd.nextg || (cmd.scan && !hit);
			if (cmd.exec) begin
				unique case (req_q.op)
					OP_ADD: if (cnt_q < CW'(ENTRY_CAPACITY)) begin
						cnt_q <= cnt_q + 1'b1;
						ne_q[cur_q] <= 1'b1;
					end
					OP_NEW: if (32'(high_q) + 1 < GROUP_CAPACITY) begin
						high_q <= high_q + 1'b1;
						cur_q <= high_q + 1'b1;
						cert_q[high_q + 1'b1] <= '0;
						ne_q[high_q + 1'b1] <= 1'b0;
					end
					OP_SEL: if (req_q.group_number <= {5'd0, high_q})
						cur_q <= req_q.group_number[GW-1:0];
					OP_CERT: cert_q[cur_q] <= req_q.certainty;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= in_data;
		if (cmd.exec) begin
			grp_q <= cur_q;
			k_q <= '0;
			ptr_q <= EW'(cnt_q - 1'b1);
			st_q <= ST_OK;
			unique case (req_q.op)
				OP_ADD: begin
					if (cnt_q >= CW'(ENTRY_CAPACITY)) st_q <= ST_FULL;
					else if (!ne_q[cur_q]) begin
						minl_q[cur_q] <= req_q.location; maxl_q[cur_q] <= req_q.location;
						mint_q[cur_q] <= req_q.timestamp; maxt_q[cur_q] <= req_q.timestamp;
					end else begin
						if (req_q.location < minl_q[cur_q]) minl_q[cur_q] <= req_q.location;
						if (req_q.location > maxl_q[cur_q]) maxl_q[cur_q] <= req_q.location;
						if (tsx < (mint_q[cur_q] ^ 64'h8000000000000000))
							mint_q[cur_q] <= req_q.timestamp;
						if (tsx > (maxt_q[cur_q] ^ 64'h8000000000000000))
							maxt_q[cur_q] <= req_q.timestamp;
					end
				end
				OP_NEW: if (32'(high_q) + 1 >= GROUP_CAPACITY) st_q <= ST_GFULL;
				OP_SEL: if (req_q.group_number > {5'd0, high_q}) st_q <= ST_NOGROUP;
				default: ;
			endcase
		end
		if (cmd.scan && !hit) ptr_q <= ptr_q - 1'b1;
		if (cmd.nextg) begin
			grp_q <= k_q[GW-1:0];
			k_q <= k_q + 1'b1;
			ptr_q <= EW'(cnt_q - 1'b1);
		end
		if (cmd.fin_ok || cmd.fin_miss || cmd.fin_hit) begin
			res_q.status <= cmd.fin_miss ? ST_NOTFOUND : (cmd.fin_hit ? ST_OK : st_q);
			res_q.found_location <= (cmd.fin_hit && cmp_signed) ? rd_loc_q : '0;
			res_q.found_timestamp <= (cmd.fin_hit && !cmp_signed) ? rd_ts_q : '0;
			res_q.current_group_out <= cur_q;
			res_q.current_certainty_out <= cert_q[cur_q];
		end
	end

	assign out_data = res_q;
endmodule
`default_nettype wire

// ===== design/grouped_time_location_index.sv =====
// A lookup walks the entry memory one entry per cycle, newest first, per group tried.
// Throughput: one beat in flight; the next is taken once the result is registered.
// Reset (arst_n low): entry count, current/highest group, certainties and
// group-nonempty flags clear; entry memory and bounds are left unwritten.
`default_nettype none
module grouped_time_location_index (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire gtli_pkg::in_t  in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output gtli_pkg::out_t      out_data
);
	import gtli_pkg::*;
	cmd_t cmd;
	sts_t sts;

	// sequence each beat: capture, execute, scan, deliver
	gtli_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.sts, .cmd
	);

	// hold tables and produce the result beat
	gtli_dp u_dp (.clk, .arst_n, .in_data, .cmd, .sts, .out_data);

	// an accepted beat always executes before it can finish
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !(cmd.fin_ok || cmd.fin_hit || cmd.fin_miss))
		else $error("finish straight after accept");
	// scan only after an accept
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> !in_ready)
		else $error("scan while idle");
endmodule
`default_nettype wire
